[rtl/maps_line_base_finder_assert.svh]
// Assertion macros for the map line base finder
`ifndef MAPS_LINE_BASE_FINDER_ASSERT_SVH
`define MAPS_LINE_BASE_FINDER_ASSERT_SVH

// checked only while out of reset
`define MLBF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MLBF_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/mlbf_pkg.sv]
// Shared types, character codes and helpers for the map line base finder
package mlbf_pkg;

  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_END   = 4'd1;
  localparam logic [3:0] PH_SP1   = 4'd2;
  localparam logic [3:0] PH_PERM  = 4'd3;
  localparam logic [3:0] PH_SP2   = 4'd4;
  localparam logic [3:0] PH_OFF   = 4'd5;
  localparam logic [3:0] PH_DEV   = 4'd6;
  localparam logic [3:0] PH_SP3   = 4'd7;
  localparam logic [3:0] PH_INODE = 4'd8;
  localparam logic [3:0] PH_SP4   = 4'd9;
  localparam logic [3:0] PH_PATH  = 4'd10;
  localparam logic [3:0] PH_DEAD  = 4'd11;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;

  localparam logic [2:0] PERM_CHARS = 3'd4;

  typedef struct packed {
    logic [3:0]  phase;
    logic [63:0] start;
    logic [2:0]  perm;
    logic [63:0] offset;
    logic        path_present;
    logic [15:0] path_start;
    logic        failed;
  } mlbf_parse_t;

  typedef struct packed {
    logic [1:0] progress;
    logic       seen;
  } mlbf_needle_t;

  localparam mlbf_parse_t PARSE_CLEAR = '{phase: PH_START, default: '0};
  localparam mlbf_needle_t NEEDLE_CLEAR = '{default: '0};

  // {valid, digit}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] needle_char(logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = CH_L;
      2'd1: r = CH_I;
      2'd2: r = CH_B;
      default: r = CH_C;
    endcase
    return r;
  endfunction

endpackage

[rtl/mlbf_needle.sv]
// Substring matcher for the library name within one line
module mlbf_needle (
  input  logic [7:0]            char_i,
  input  mlbf_pkg::mlbf_needle_t state_i,
  output mlbf_pkg::mlbf_needle_t state_o
);

  always_comb begin
    state_o = state_i;
    if (char_i == mlbf_pkg::needle_char(state_i.progress)) begin
      if (state_i.progress == 2'd3) begin
        state_o.seen     = 1'b1;
        state_o.progress = 2'd0;
      end else begin
        state_o.progress = state_i.progress + 2'd1;
      end
    end else begin
      state_o.progress = (char_i == mlbf_pkg::CH_L) ? 2'd1 : 2'd0;
    end
  end

endmodule

[rtl/mlbf_fields.sv]
// Field parser: next line parse state for one text byte
module mlbf_fields (
  input  logic [7:0]            char_i,
  input  logic [15:0]           pos_i,
  input  mlbf_pkg::mlbf_parse_t state_i,
  output mlbf_pkg::mlbf_parse_t state_o
);

  logic [4:0] hex;
  logic       is_hex;
  logic       is_space;

  assign hex      = mlbf_pkg::hex_value(char_i);
  assign is_hex   = hex[4];
  assign is_space = (char_i == mlbf_pkg::CH_SPACE);

  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      mlbf_pkg::PH_START: begin
        if (is_hex) begin
          state_o.start = {state_i.start[59:0], hex[3:0]};
        end else if (char_i == mlbf_pkg::CH_DASH) begin
          state_o.phase = mlbf_pkg::PH_END;
        end else begin
          state_o.failed = 1'b1;
          state_o.phase  = mlbf_pkg::PH_DEAD;
        end
      end
      mlbf_pkg::PH_END: begin
        if (!is_hex) begin
          if (is_space) begin
            state_o.phase = mlbf_pkg::PH_SP1;
          end else begin
            state_o.phase = mlbf_pkg::PH_PERM;
            state_o.perm  = state_i.perm + 3'd1;
          end
        end
      end
      mlbf_pkg::PH_SP1: begin
        if (!is_space) begin
          state_o.phase = mlbf_pkg::PH_PERM;
          state_o.perm  = state_i.perm + 3'd1;
        end
      end
      mlbf_pkg::PH_PERM: begin
        state_o.perm = state_i.perm + 3'd1;
        if (state_i.perm + 3'd1 >= mlbf_pkg::PERM_CHARS) begin
          state_o.phase = mlbf_pkg::PH_SP2;
        end
      end
      mlbf_pkg::PH_SP2, mlbf_pkg::PH_OFF: begin
        if (is_hex) begin
          state_o.phase  = mlbf_pkg::PH_OFF;
          state_o.offset = {state_i.offset[59:0], hex[3:0]};
        end else if (is_space) begin
          if (state_i.phase == mlbf_pkg::PH_OFF) begin
            state_o.phase = mlbf_pkg::PH_SP3;
          end
        end else begin
          state_o.phase = mlbf_pkg::PH_DEV;
        end
      end
      mlbf_pkg::PH_DEV: begin
        if (is_space) begin
          state_o.phase = mlbf_pkg::PH_SP3;
        end
      end
      mlbf_pkg::PH_SP3: begin
        if (!is_space) begin
          state_o.phase = mlbf_pkg::PH_INODE;
        end
      end
      mlbf_pkg::PH_INODE: begin
        if (is_space) begin
          state_o.phase = mlbf_pkg::PH_SP4;
        end
      end
      mlbf_pkg::PH_SP4: begin
        if (!is_space) begin
          state_o.phase        = mlbf_pkg::PH_PATH;
          state_o.path_present = 1'b1;
          state_o.path_start   = pos_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/maps_line_base_finder.sv]
// Top level: map text scanner that reports the library base address
//
// Input channel: text_byte_i/last_byte_i with in_valid_i, in_stall_o. An item
// is taken at a clock edge with valid high and stall low. A zero byte or an
// item with last_byte_i set ends the text.
// Output channel: found_o, base_address_o, path_position_o with out_valid_o,
// out_stall_i. At most one result per text: found_o=1 with the start address
// and path byte position of the first qualifying line, or found_o=0 with zero
// payload when the text ends without one.
// Pipeline: each byte passes through an input register, parse and match logic,
// and a result register; out_valid_o rises once the result register is loaded.
// Throughput: one byte per cycle while no pending result is held by out_stall_i.
// Receiver stall: a pending result holds; the input register then holds its
// byte and in_stall_o rises until the result slot frees.
// Reset: clears both pipeline valid flags, the line state, the byte position
// and the found latch. Bytes past TEXT_BYTES are ignored until text end.
module maps_line_base_finder #(
  parameter int TEXT_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] base_address_o,
  output logic [15:0] path_position_o
);

  localparam logic [15:0] TextLimit = 16'(TEXT_BYTES);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q, out_valid_d;
  logic        out_found_q;
  logic [63:0] out_base_q;
  logic [15:0] out_path_q;

  mlbf_pkg::mlbf_parse_t  parse_q, parse_d, parse_upd, parse_eff;
  mlbf_pkg::mlbf_needle_t needle_q, needle_d, needle_upd, needle_eff;
  logic [15:0] pos_q, pos_d, pos_inc;
  logic        hit_q, hit_d;

  logic advance, in_range, active, is_lf, end_text, judge_now, hit, has_result;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= text_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  mlbf_needle u_needle (
    .char_i  (in_byte_q),
    .state_i (needle_q),
    .state_o (needle_upd)
  );

  mlbf_fields u_fields (
    .char_i  (in_byte_q),
    .pos_i   (pos_q),
    .state_i (parse_q),
    .state_o (parse_upd)
  );

  assign pos_inc   = pos_q + 16'd1;
  assign in_range  = pos_q < TextLimit;
  assign is_lf     = in_byte_q == mlbf_pkg::CH_LF;
  assign end_text  = (in_byte_q == mlbf_pkg::CH_NUL) || in_last_q;
  assign active    = in_range && (in_byte_q != mlbf_pkg::CH_NUL) && !hit_q;
  assign parse_eff  = (active && !is_lf) ? parse_upd : parse_q;
  assign needle_eff = (active && !is_lf) ? needle_upd : needle_q;
  assign judge_now = in_range && ((active && is_lf) || end_text || pos_inc == TextLimit);
  assign hit = judge_now && !hit_q && needle_eff.seen && !parse_eff.failed &&
               parse_eff.path_present && (parse_eff.offset == 64'd0);
  assign has_result = hit || (end_text && !hit_q);

  always_comb begin
    parse_d  = parse_eff;
    needle_d = needle_eff;
    pos_d    = in_range ? pos_inc : pos_q;
    hit_d    = hit_q || hit;
    if (judge_now || end_text) begin
      parse_d  = mlbf_pkg::PARSE_CLEAR;
      needle_d = mlbf_pkg::NEEDLE_CLEAR;
    end
    if (end_text) begin
      pos_d = 16'd0;
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q  <= mlbf_pkg::PARSE_CLEAR;
      needle_q <= mlbf_pkg::NEEDLE_CLEAR;
      pos_q    <= 16'd0;
      hit_q    <= 1'b0;
    end else if (advance) begin
      parse_q  <= parse_d;
      needle_q <= needle_d;
      pos_q    <= pos_d;
      hit_q    <= hit_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_found_q <= hit;
      out_base_q  <= hit ? parse_eff.start : 64'd0;
      out_path_q  <= hit ? parse_eff.path_start : 16'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign base_address_o  = out_base_q;
  assign path_position_o = out_path_q;

  `include "maps_line_base_finder_assert.svh"

  `MLBF_ASSERT_RST(a_notfound_zero, out_valid_o && !found_o |-> base_address_o == 64'd0 && path_position_o == 16'd0, "not-found result with nonzero payload")
  `MLBF_ASSERT_RST(a_single_hit, advance && hit_q |-> !hit, "second match within one text")
  `MLBF_ASSERT_RST(a_pos_bound, pos_q <= TextLimit, "byte position past buffer limit")
  `MLBF_ASSERT_RST(a_result_loaded, advance && has_result |=> out_valid_q, "result not registered")

endmodule
